[rtl/smts_pkg.sv]
package smts_pkg;

    localparam int KEY_W          = 32;
    localparam int ROW_W          = 16;
    localparam int COL_W          = 16;
    localparam int VALUE_W        = 64;
    localparam int ENTRY_COUNT_W  = 7;
    localparam int DEF_CAPACITY   = 64;
    localparam logic [COL_W-1:0] NUM_COLS_RESET = COL_W'(1);

    typedef logic [1:0] t_op;

    localparam t_op OP_HOLD   = 2'd0;
    localparam t_op OP_INSERT = 2'd1;
    localparam t_op OP_DELETE = 2'd2;
    localparam t_op OP_UPDATE = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic ge;
        logic eq;
        logic hit;
    } t_cell_flags;

endpackage

[rtl/smts_cell.sv]
module smts_cell
    import smts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_cmp_en,
    input  logic        i_occupied,
    input  t_entry      i_req,
    input  t_op         i_op,
    input  logic        i_ge_left,
    input  t_entry      i_left,
    input  t_entry      i_right,
    output t_entry      o_entry,
    output t_cell_flags o_flags
);

    t_entry      r_entry;
    t_cell_flags r_flags;

    // empty cells compare as above every key so an append lands on the first one
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_flags.ge  <= !i_occupied || (r_entry.key >= i_req.key);
            r_flags.eq  <= i_occupied && (r_entry.key == i_req.key);
            r_flags.hit <= i_occupied && (r_entry.row == i_req.row)
                           && (r_entry.col == i_req.col);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_HOLD: begin
                r_entry <= r_entry;
            end
            OP_INSERT: begin
                if (r_flags.ge && !i_ge_left) begin
                    r_entry <= i_req;
                end else if (i_ge_left) begin
                    r_entry <= i_left;
                end
            end
            OP_DELETE: begin
                if (r_flags.ge) begin
                    r_entry <= i_right;
                end
            end
            OP_UPDATE: begin
                if (r_flags.eq) begin
                    r_entry.value <= i_req.value;
                end
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

[rtl/sparse_matrix_tuple_store.sv]
// Sorted coordinate store for the nonzero entries of a sparse matrix, held in a
// row of CAPACITY cells ordered by the key row*num_cols+col. A request is taken
// when the block is idle and its result is written to the output register:
// the key is formed in the 16x16 multiplier as the request is taken, in the
// compare state every cell compares its entry against the request, and the
// resolve state resolves the position and shifts the row by one place for an
// insert or delete. The block takes no new request before it is through with
// the last, as it is ready only when idle; the resolve state waits while an
// earlier result is still held in the output register. A set with a zero value
// (either signed zero) deletes, an insert into a full table is dropped with
// status 1, and num_cols may be written whenever no request is in flight;
// stored entries keep the key formed when inserted.
module sparse_matrix_tuple_store
    import smts_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [COL_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic [ROW_W-1:0]         i_row,
    input  logic [COL_W-1:0]         i_col,
    input  logic [VALUE_W-1:0]       i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [VALUE_W-1:0]       o_value_out,
    output logic                     o_found,
    output logic [ENTRY_COUNT_W-1:0] o_entry_count,
    output logic                     o_status
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [COL_W-1:0]    r_num_cols;
    logic                r_action;
    t_entry              r_req;

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_value_out, n_value_out;
    logic                r_found, n_found;
    logic                r_status, n_status;

    t_entry              cell_entry [CAPACITY];
    t_cell_flags         cell_flags [CAPACITY];
    logic [CAPACITY-1:0] ge_vec, eq_vec, hit_vec, first_hit;
    t_op                 op;
    logic                res_fire;
    logic                cmp_en;
    logic                in_fire;
    logic                is_zero;
    logic                key_found;
    logic                full;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cmp_en      = (r_state == ST_CMP);
    assign res_fire    = (r_state == ST_RES) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= NUM_COLS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_cols <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action    <= i_action;
            r_req.key   <= KEY_W'(i_row) * KEY_W'(r_num_cols) + KEY_W'(i_col);
            r_req.row   <= i_row;
            r_req.col   <= i_col;
            r_req.value <= i_value;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic   occupied;
            logic   ge_left;
            t_entry left_entry;
            t_entry right_entry;

            assign occupied = (CW'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign ge_left    = 1'b0;
                assign left_entry = cell_entry[gi];
            end else begin : g_body
                assign ge_left    = cell_flags[gi-1].ge;
                assign left_entry = cell_entry[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign right_entry = cell_entry[gi];
            end else begin : g_inner
                assign right_entry = cell_entry[gi+1];
            end

            smts_cell u_cell (
                .i_clk      (i_clk),
                .i_cmp_en   (cmp_en),
                .i_occupied (occupied),
                .i_req      (r_req),
                .i_op       (op),
                .i_ge_left  (ge_left),
                .i_left     (left_entry),
                .i_right    (right_entry),
                .o_entry    (cell_entry[gi]),
                .o_flags    (cell_flags[gi])
            );

            assign ge_vec[gi]  = cell_flags[gi].ge;
            assign eq_vec[gi]  = cell_flags[gi].eq;
            assign hit_vec[gi] = cell_flags[gi].hit;
        end
    endgenerate

    // lowest set bit is the first match in key order
    assign first_hit = hit_vec & (~hit_vec + CAPACITY'(1));

    assign is_zero   = (r_req.value[VALUE_W-2:0] == '0);
    assign key_found = |eq_vec;
    assign full      = (r_count == CW'(CAPACITY));

    always_comb begin
        op          = OP_HOLD;
        n_count     = r_count;
        n_value_out = '0;
        n_found     = 1'b0;
        n_status    = 1'b0;
        if (r_action) begin
            n_found = |hit_vec;
            for (int i = 0; i < CAPACITY; i++) begin
                if (first_hit[i]) begin
                    n_value_out = n_value_out | cell_entry[i].value;
                end
            end
        end else begin
            n_found = key_found;
            if (key_found && is_zero) begin
                op      = OP_DELETE;
                n_count = r_count - CW'(1);
            end else if (key_found) begin
                op = OP_UPDATE;
            end else if (!is_zero) begin
                if (full) begin
                    n_status = 1'b1;
                end else begin
                    op      = OP_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
        end
        if (!res_fire) begin
            op      = OP_HOLD;
            n_count = r_count;
        end
        // no insert without a free slot at or after the position
        if (ge_vec == '0 && op == OP_INSERT) begin
            op = OP_HOLD;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_RES;
            end
            ST_RES: begin
                if (res_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (res_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_fire) begin
            r_value_out <= n_value_out;
            r_found     <= n_found;
            r_status    <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value_out   = r_value_out;
    assign o_found       = r_found;
    assign o_status      = r_status;
    assign o_entry_count = ENTRY_COUNT_W'(r_count);

endmodule
